/* hw/rtl/rau_pkg.sv */
// Shared constants and operation codes for the rational arithmetic unit.
package rau_pkg;

    localparam int unsigned OP_W   = 4;
    localparam int unsigned NUM_W  = 32;
    localparam int unsigned DEN_W  = 31;
    localparam int unsigned WIDE_W = 64;

    localparam logic [OP_W-1:0] OP_ADD   = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB   = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL   = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV   = 4'd3;
    localparam logic [OP_W-1:0] OP_LT    = 4'd4;
    localparam logic [OP_W-1:0] OP_LE    = 4'd5;
    localparam logic [OP_W-1:0] OP_GT    = 4'd6;
    localparam logic [OP_W-1:0] OP_GE    = 4'd7;
    localparam logic [OP_W-1:0] OP_EQ    = 4'd8;
    localparam logic [OP_W-1:0] OP_NE    = 4'd9;
    localparam logic [OP_W-1:0] OP_NEG   = 4'd10;
    localparam logic [OP_W-1:0] OP_RECIP = 4'd11;

    // Comparison ops share the cross-multiply path and skip the final reduction.
    function automatic logic is_cmp(input logic [OP_W-1:0] op);
        return (op == OP_LT) || (op == OP_LE) || (op == OP_GT) ||
               (op == OP_GE) || (op == OP_EQ) || (op == OP_NE);
    endfunction

endpackage

/* hw/rtl/rau_req_if.sv */
// Request channel: operation code and two rational operands.
interface rau_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  req_type;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;

    modport source (output valid, req_type, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, req_type, a_num, a_den, b_num, b_den, output ready);
endinterface

/* hw/rtl/rau_rsp_if.sv */
// Response channel: reduced rational result and flags.
interface rau_rsp_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] res_num;
    logic [30:0] res_den;
    logic        cmp_true;
    logic        overflow;

    modport source (output valid, res_num, res_den, cmp_true, overflow, input ready);
    modport sink   (input valid, res_num, res_den, cmp_true, overflow, output ready);
endinterface

/* hw/rtl/rau_reduce.sv */
// Iterative gcd reduction: binary gcd, then two restoring divisions by the gcd.
module rau_reduce import rau_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WIDE_W-1:0] i_mag,
    input  logic [WIDE_W-1:0] i_den,
    output logic              o_done,
    output logic [WIDE_W-1:0] o_mag,
    output logic [WIDE_W-1:0] o_den
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_GCD  = 2'd1;
    localparam logic [1:0] S_DIVM = 2'd2;
    localparam logic [1:0] S_DIVD = 2'd3;

    logic [1:0]        r_state;
    logic              r_done;
    logic [5:0]        r_cnt;
    logic [WIDE_W-1:0] r_m, r_d, r_x, r_y, r_q, r_r;

    logic [WIDE_W:0]   rsh;
    logic              ge;
    logic [WIDE_W-1:0] rem_nx;
    logic [WIDE_W-1:0] q_nx;
    logic              x_gt;
    logic [WIDE_W-1:0] gdiff;

    // One division step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        rsh    = {r_r, r_q[WIDE_W-1]};
        ge     = (rsh >= {1'b0, r_x});
        rem_nx = ge ? WIDE_W'(rsh - {1'b0, r_x}) : rsh[WIDE_W-1:0];
        q_nx   = {r_q[WIDE_W-2:0], ge};
        x_gt   = (r_x > r_y);
        gdiff  = x_gt ? (r_x - r_y) : (r_y - r_x);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if (i_mag == '0 || i_den == '0) begin
                            r_m    <= '0;
                            r_d    <= WIDE_W'(1);
                            r_done <= 1'b1;
                        end else begin
                            r_m     <= i_mag;
                            r_d     <= i_den;
                            r_x     <= i_mag;
                            r_y     <= i_den;
                            r_state <= S_GCD;
                        end
                    end
                end
                S_GCD: begin
                    if (!r_x[0] && !r_y[0]) begin
                        // drop a common factor of two from everything
                        r_x <= r_x >> 1;
                        r_y <= r_y >> 1;
                        r_m <= r_m >> 1;
                        r_d <= r_d >> 1;
                    end else if (!r_x[0]) begin
                        r_x <= r_x >> 1;
                    end else if (!r_y[0]) begin
                        r_y <= r_y >> 1;
                    end else if (r_x == r_y) begin
                        r_q     <= r_m;
                        r_r     <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIVM;
                    end else if (x_gt) begin
                        r_x <= gdiff;
                    end else begin
                        r_y <= gdiff;
                    end
                end
                S_DIVM: begin
                    r_q   <= q_nx;
                    r_r   <= rem_nx;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_m     <= q_nx;
                        r_q     <= r_d;
                        r_r     <= '0;
                        r_state <= S_DIVD;
                    end
                end
                S_DIVD: begin
                    r_q   <= q_nx;
                    r_r   <= rem_nx;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_d     <= q_nx;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_mag  = r_m;
    assign o_den  = r_d;

endmodule

/* hw/rtl/rational_arithmetic_unit.sv */
// Top level of the rational arithmetic unit: sequencer, shared multiplier, reducer.
//
//  channel   dir  handshake            beat contents
//  i_req     in   valid/ready          req_type, a_num, a_den, b_num, b_den
//  o_rsp     out  valid/ready          res_num, res_den, cmp_true, overflow
//
// One beat at a time: i_req.ready is high only in idle; the next request waits
// until the response beat has been taken.
// Steps per request: accept, three reductions (operand a, operand b, result), three
// multiplies, one combine step and the response beat. A nonzero reduction runs a start
// step, a binary gcd loop (one shift or subtract a cycle) and two restoring divisions;
// a zero reduction skips the gcd loop and both divisions. Comparisons skip the result
// reduction, and unused codes answer 0/1 straight after accept.
// Reset (i_rst_n low, synchronous) returns the sequencer and reducer to idle and
// drops o_rsp.valid. A stalled response holds its beat unchanged.
module rational_arithmetic_unit import rau_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rau_req_if.sink   i_req,
    rau_rsp_if.source o_rsp
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LDA_GO = 4'd1;
    localparam logic [3:0] S_LDA_W  = 4'd2;
    localparam logic [3:0] S_LDB_GO = 4'd3;
    localparam logic [3:0] S_LDB_W  = 4'd4;
    localparam logic [3:0] S_MUL0   = 4'd5;
    localparam logic [3:0] S_MUL1   = 4'd6;
    localparam logic [3:0] S_MUL2   = 4'd7;
    localparam logic [3:0] S_COMB   = 4'd8;
    localparam logic [3:0] S_RED_GO = 4'd9;
    localparam logic [3:0] S_RED_W  = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;

    logic [3:0]        r_state;
    logic [OP_W-1:0]   r_op;
    logic              r_a_neg, r_b_neg, r_rneg;
    logic [NUM_W-1:0]  r_amag, r_aden, r_bmag, r_bden;
    logic [WIDE_W-1:0] r_p0, r_p1, r_p2, r_nmag;

    logic              r_ovalid;
    logic [NUM_W-1:0]  r_res_num;
    logic [DEN_W-1:0]  r_res_den;
    logic              r_cmp, r_ovf;

    // reducer hookup
    logic              red_start, red_done;
    logic [WIDE_W-1:0] red_in_mag, red_in_den, red_mag, red_den;

    // multiplier operands
    logic [NUM_W-1:0]  mul_a, mul_b;
    logic [WIDE_W-1:0] prod;

    // combine / compare
    logic              yn;
    logic [WIDE_W-1:0] sum_mag;
    logic              sum_neg;
    logic signed [WIDE_W-1:0] lhs, rhs;
    logic              cmp_v;
    logic              res_fits;
    logic [NUM_W-1:0]  res_num_nx;

    function automatic logic [NUM_W-1:0] abs32(input logic [NUM_W-1:0] v);
        return v[NUM_W-1] ? (~v + NUM_W'(1)) : v;
    endfunction

    rau_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (red_start),
        .i_mag   (red_in_mag),
        .i_den   (red_in_den),
        .o_done  (red_done),
        .o_mag   (red_mag),
        .o_den   (red_den)
    );

    // Steer the reducer to operand a, operand b or the raw result.
    always_comb begin
        red_start  = (r_state == S_LDA_GO) || (r_state == S_LDB_GO) ||
                     (r_state == S_RED_GO);
        red_in_mag = {32'd0, r_amag};
        red_in_den = {32'd0, r_aden};
        case (r_state)
            S_LDB_GO: begin
                red_in_mag = {32'd0, r_bmag};
                red_in_den = {32'd0, r_bden};
            end
            S_RED_GO: begin
                red_in_mag = r_nmag;
                red_in_den = r_p2;
            end
            default: ;
        endcase
    end

    // Pick the factor pair for this multiply step.
    always_comb begin
        mul_a = r_amag;
        mul_b = r_bden;
        case (r_state)
            S_MUL0: begin
                case (r_op)
                    OP_MUL:   mul_b = r_bmag;
                    OP_NEG:   mul_b = NUM_W'(1);
                    OP_RECIP: begin
                        mul_a = r_aden;
                        mul_b = NUM_W'(1);
                    end
                    default: ;
                endcase
            end
            S_MUL1: begin
                mul_a = r_bmag;
                mul_b = r_aden;
            end
            S_MUL2: begin
                mul_a = r_aden;
                case (r_op)
                    OP_DIV:   mul_b = r_bmag;
                    OP_NEG:   mul_b = NUM_W'(1);
                    OP_RECIP: begin
                        mul_a = r_amag;
                        mul_b = NUM_W'(1);
                    end
                    default: mul_b = r_bden;
                endcase
            end
            default: ;
        endcase
        prod = WIDE_W'(mul_a) * WIDE_W'(mul_b);
    end

    // Signed sum of the cross products, numerator sign for the other ops, compare result and fit check.
    always_comb begin
        yn = (r_op == OP_SUB) ? !r_b_neg : r_b_neg;
        if (r_op == OP_ADD || r_op == OP_SUB) begin
            if (r_a_neg == yn) begin
                sum_mag = r_p0 + r_p1;
                sum_neg = r_a_neg;
            end else if (r_p0 >= r_p1) begin
                sum_mag = r_p0 - r_p1;
                sum_neg = r_a_neg;
            end else begin
                sum_mag = r_p1 - r_p0;
                sum_neg = yn;
            end
        end else begin
            sum_mag = r_p0;
            case (r_op)
                OP_NEG:   sum_neg = !r_a_neg;
                OP_RECIP: sum_neg = r_a_neg;
                default:  sum_neg = r_a_neg ^ r_b_neg;
            endcase
        end

        lhs = r_a_neg ? -$signed(r_p0) : $signed(r_p0);
        rhs = r_b_neg ? -$signed(r_p1) : $signed(r_p1);
        case (r_op)
            OP_LT:   cmp_v = lhs <  rhs;
            OP_LE:   cmp_v = lhs <= rhs;
            OP_GT:   cmp_v = lhs >  rhs;
            OP_GE:   cmp_v = lhs >= rhs;
            OP_EQ:   cmp_v = lhs == rhs;
            default: cmp_v = lhs != rhs;
        endcase

        res_fits   = (red_mag[WIDE_W-1:DEN_W] == '0) && (red_den[WIDE_W-1:DEN_W] == '0);
        res_num_nx = (r_rneg && red_mag != '0) ? (~red_mag[NUM_W-1:0] + NUM_W'(1))
                                               : red_mag[NUM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op    <= i_req.req_type;
                        r_a_neg <= i_req.a_num[31] ^ i_req.a_den[31];
                        r_b_neg <= i_req.b_num[31] ^ i_req.b_den[31];
                        r_amag  <= abs32(i_req.a_num);
                        r_aden  <= abs32(i_req.a_den);
                        r_bmag  <= abs32(i_req.b_num);
                        r_bden  <= abs32(i_req.b_den);
                        if (i_req.req_type > OP_RECIP) begin
                            // unused code: answer 0/1 right away
                            r_res_num <= '0;
                            r_res_den <= DEN_W'(1);
                            r_cmp     <= 1'b0;
                            r_ovf     <= 1'b0;
                            r_ovalid  <= 1'b1;
                            r_state   <= S_OUT;
                        end else begin
                            r_state <= S_LDA_GO;
                        end
                    end
                end
                S_LDA_GO: r_state <= S_LDA_W;
                S_LDA_W: begin
                    if (red_done) begin
                        r_amag  <= red_mag[NUM_W-1:0];
                        r_aden  <= red_den[NUM_W-1:0];
                        r_a_neg <= r_a_neg && (red_mag != '0);
                        r_state <= S_LDB_GO;
                    end
                end
                S_LDB_GO: r_state <= S_LDB_W;
                S_LDB_W: begin
                    if (red_done) begin
                        r_bmag  <= red_mag[NUM_W-1:0];
                        r_bden  <= red_den[NUM_W-1:0];
                        r_b_neg <= r_b_neg && (red_mag != '0);
                        r_state <= S_MUL0;
                    end
                end
                S_MUL0: begin
                    r_p0    <= prod;
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_p1    <= prod;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_p2    <= prod;
                    r_state <= S_COMB;
                end
                S_COMB: begin
                    if (is_cmp(r_op)) begin
                        r_res_num <= '0;
                        r_res_den <= DEN_W'(1);
                        r_cmp     <= cmp_v;
                        r_ovf     <= 1'b0;
                        r_ovalid  <= 1'b1;
                        r_state   <= S_OUT;
                    end else begin
                        r_nmag  <= sum_mag;
                        r_rneg  <= sum_neg;
                        r_state <= S_RED_GO;
                    end
                end
                S_RED_GO: r_state <= S_RED_W;
                S_RED_W: begin
                    if (red_done) begin
                        r_cmp <= 1'b0;
                        if (res_fits) begin
                            r_res_num <= res_num_nx;
                            r_res_den <= red_den[DEN_W-1:0];
                            r_ovf     <= 1'b0;
                        end else begin
                            r_res_num <= '0;
                            r_res_den <= DEN_W'(1);
                            r_ovf     <= 1'b1;
                        end
                        r_ovalid <= 1'b1;
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold the beat until the sink takes it
                    if (o_rsp.ready) begin
                        r_ovalid <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready    = (r_state == S_IDLE);
    assign o_rsp.valid    = r_ovalid;
    assign o_rsp.res_num  = r_res_num;
    assign o_rsp.res_den  = r_res_den;
    assign o_rsp.cmp_true = r_cmp;
    assign o_rsp.overflow = r_ovf;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !i_req.ready)
        else $error("request accepted while a response is pending");

    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.overflow) |-> (o_rsp.res_num == '0 && o_rsp.res_den == DEN_W'(1)))
        else $error("overflow response is not 0/1");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.res_den != '0))
        else $error("zero denominator in response");

    a_cmp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.cmp_true) |-> (!o_rsp.overflow && o_rsp.res_num == '0))
        else $error("comparison response carries arithmetic data");

    a_red_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        red_done |-> (r_state == S_LDA_W || r_state == S_LDB_W || r_state == S_RED_W))
        else $error("reducer finished while sequencer was not waiting");

endmodule
